// File: rtl/tds_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the task dispatch selector.
package tds_pkg;

  localparam int MAX_WORKERS   = 16;
  localparam int PLAN_DEPTH    = 16;
  localparam int COUNT_WIDTH   = 16;
  localparam int TASK_ID_WIDTH = 32;

  localparam int WORKER_W   = 4;   // worker index field
  localparam int NCNT_W     = 5;   // worker count 0..16
  localparam int PLAN_IDX_W = 4;
  localparam int PLAN_VAL_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int STATUS_W   = 2;

  // remainder unit: bits folded in per cycle and steps per item
  localparam int REM_BITS  = 4;
  localparam int REM_STEPS = TASK_ID_WIDTH / REM_BITS;
  localparam int REM_CNT_W = $clog2(REM_STEPS);

  typedef enum logic [1:0] {
    SCHED_PLANNED = 2'd0,
    SCHED_RR      = 2'd1,
    SCHED_LEAST   = 2'd2
  } sched_mode_e;

  typedef enum logic [1:0] {
    THR_POOL  = 2'd0,
    THR_PLAN  = 2'd1,
    THR_CONST = 2'd2
  } thread_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_COUNT_ERR = 2'd1,
    ST_IGNORED   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCHED_MODE   = 3'd0,
    CFG_THREAD_MODE  = 3'd1,
    CFG_HW_THREADS   = 3'd2,
    CFG_REQ_THREADS  = 3'd3,
    CFG_PLAN_LENGTH  = 3'd4,
    CFG_PLAN_ENTRIES = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PSCAN,
    S_NCALC,
    S_ROUTE,
    S_DIV1,
    S_DIV2,
    S_ASCAN,
    S_UPDATE
  } state_e;

  typedef enum logic [1:0] {
    DIV_TID_LEN,
    DIV_TID_N,
    DIV_PV_N
  } div_sel_e;

  typedef enum logic [1:0] {
    W_DONE,
    W_REM,
    W_MIN
  } w_src_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     in_ready;
    logic     load;
    logic     pscan_step;
    logic     ncalc;
    logic     div_start;
    div_sel_e div_sel;
    logic     ascan_clr;
    logic     ascan_step;
    logic     w_load;
    w_src_e   w_src;
    logic     update;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_valid;
    logic plan_active;
    logic pscan_last;
    logic n_zero;
    logic is_done_req;
    logic sched_planned;
    logic sched_rr;
    logic div_done;
    logic ascan_end;
    logic out_free;
  } dp_stat_t;

  // raw planner value v means worker v-1, raw 0 means worker 0
  function automatic logic [PLAN_VAL_W-1:0] plan_value(
    input logic [CFG_DATA_W-1:0] entries,
    input logic [PLAN_IDX_W-1:0] k
  );
    logic [PLAN_VAL_W-1:0] raw;
    raw = entries[k*PLAN_VAL_W +: PLAN_VAL_W];
    return (raw == '0) ? '0 : raw - PLAN_VAL_W'(1);
  endfunction

endpackage

// File: rtl/tds_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the task dispatch selector.
interface tds_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [tds_pkg::TASK_ID_WIDTH-1:0]  task_id;
  logic [tds_pkg::WORKER_W-1:0]       done_worker;

  modport source (output valid, req_type, task_id, done_worker, input ready);
  modport sink   (input valid, req_type, task_id, done_worker, output ready);
endinterface

interface tds_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [tds_pkg::WORKER_W-1:0]   worker;
  logic [tds_pkg::STATUS_W-1:0]   status;
  logic [tds_pkg::COUNT_WIDTH-1:0] pending_after;

  modport source (output valid, worker, status, pending_after, input ready);
  modport sink   (input valid, worker, status, pending_after, output ready);
endinterface

// File: rtl/tds_rem.sv
`timescale 1ns / 1ps
// Iterative remainder unit: task id modulo a small count, a few bits per cycle.
module tds_rem (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [tds_pkg::TASK_ID_WIDTH-1:0]  dividend_i,
  input  logic [tds_pkg::NCNT_W-1:0]         divisor_i,
  output logic [tds_pkg::NCNT_W-1:0]         rem_o,
  output logic                               done_o
);
  import tds_pkg::*;

  logic [TASK_ID_WIDTH-1:0] dvd_q;
  logic [NCNT_W-1:0]        div_q;
  logic [NCNT_W-1:0]        rem_q, rem_d;
  logic [REM_CNT_W-1:0]     cnt_q;
  logic                     busy_q, done_q;

  // fold the next few dividend bits into the partial remainder
  always_comb begin
    rem_d = rem_q;
    for (int j = 0; j < REM_BITS; j++) begin
      rem_d = {rem_d[NCNT_W-2:0], dvd_q[TASK_ID_WIDTH-1-j]};
      if (rem_d >= div_q) begin
        rem_d = rem_d - div_q;
      end
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + REM_CNT_W'(1);
      if (cnt_q == REM_CNT_W'(REM_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << REM_BITS;
      rem_q <= rem_d;
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// File: rtl/tds_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the task dispatch selector.
module tds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tds_pkg::dp_stat_t   stat_i,
  output tds_pkg::ctrl_cmd_t  cmd_o
);
  import tds_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (stat_i.in_valid) begin
          state_d = stat_i.plan_active ? S_PSCAN : S_NCALC;
        end
      end
      S_PSCAN: begin
        if (stat_i.pscan_last) begin
          state_d = S_NCALC;
        end
      end
      S_NCALC: state_d = S_ROUTE;
      S_ROUTE: begin
        priority if (stat_i.n_zero || stat_i.is_done_req) begin
          state_d = S_UPDATE;
        end else if (stat_i.sched_planned || stat_i.sched_rr) begin
          state_d = S_DIV1;
        end else begin
          state_d = S_ASCAN;
        end
      end
      S_DIV1: begin
        if (stat_i.div_done) begin
          state_d = stat_i.sched_planned ? S_DIV2 : S_UPDATE;
        end
      end
      S_DIV2: begin
        if (stat_i.div_done) begin
          state_d = S_UPDATE;
        end
      end
      S_ASCAN: begin
        if (stat_i.ascan_end) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_TID_N;
    cmd_o.w_src   = W_DONE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = stat_i.in_valid;
      end
      S_PSCAN: cmd_o.pscan_step = 1'b1;
      S_NCALC: cmd_o.ncalc = 1'b1;
      S_ROUTE: begin
        priority if (stat_i.n_zero || stat_i.is_done_req) begin
          cmd_o.w_load = 1'b1;
          cmd_o.w_src  = W_DONE;
        end else if (stat_i.sched_planned) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_TID_LEN;
        end else if (stat_i.sched_rr) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_TID_N;
        end else begin
          cmd_o.ascan_clr = 1'b1;
        end
      end
      S_DIV1: begin
        if (stat_i.div_done) begin
          if (stat_i.sched_planned) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_PV_N;
          end else begin
            cmd_o.w_load = 1'b1;
            cmd_o.w_src  = W_REM;
          end
        end
      end
      S_DIV2: begin
        if (stat_i.div_done) begin
          cmd_o.w_load = 1'b1;
          cmd_o.w_src  = W_REM;
        end
      end
      S_ASCAN: begin
        if (stat_i.ascan_end) begin
          cmd_o.w_load = 1'b1;
          cmd_o.w_src  = W_MIN;
        end else begin
          cmd_o.ascan_step = 1'b1;
        end
      end
      S_UPDATE: cmd_o.update = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/tds_dpath.sv
`timescale 1ns / 1ps
// Datapath: settings, pending counters, worker selection and result register.
module tds_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tds_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tds_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  tds_req_if.sink                            req,
  tds_rsp_if.source                          rsp,
  input  tds_pkg::ctrl_cmd_t                 cmd_i,
  output tds_pkg::dp_stat_t                  stat_o
);
  import tds_pkg::*;

  // settings
  logic [1:0]            sched_q, thr_q;
  logic [NCNT_W-1:0]     hw_q, rqt_q, plen_q;
  logic [CFG_DATA_W-1:0] plan_q;

  // item and working registers
  logic                     req_type_q;
  logic [TASK_ID_WIDTH-1:0] tid_q;
  logic [WORKER_W-1:0]      dw_q;
  logic [PLAN_IDX_W-1:0]    k_q;
  logic [PLAN_VAL_W-1:0]    mx_q;
  logic [NCNT_W-1:0]        n_q, n_d;
  logic [NCNT_W-1:0]        i_q;
  logic [WORKER_W-1:0]      best_q;
  logic [COUNT_WIDTH-1:0]   bestv_q;
  logic [WORKER_W-1:0]      w_q, w_d;
  logic [COUNT_WIDTH-1:0]   cnt_q [MAX_WORKERS];

  // result register
  logic                     out_valid_q;
  logic [WORKER_W-1:0]      out_worker_q;
  logic [STATUS_W-1:0]      out_status_q;
  logic [COUNT_WIDTH-1:0]   out_pend_q;

  logic [NCNT_W-1:0]        len_eff, hw_eff, mx_inc;
  logic [PLAN_VAL_W-1:0]    pv_scan, pv_rem;
  logic [TASK_ID_WIDTH-1:0] div_dvd;
  logic [NCNT_W-1:0]        div_dsr, rem;
  logic                     div_done;
  logic [WORKER_W-1:0]      rd_idx;
  logic [COUNT_WIDTH-1:0]   rd_val, upd_val;
  logic                     dw_out_of_range, upd_write;
  logic [WORKER_W-1:0]      upd_worker;
  logic [STATUS_W-1:0]      upd_status;
  logic [COUNT_WIDTH-1:0]   upd_pend;
  logic                     out_free;

  // hold settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_q <= SCHED_RR;
      thr_q   <= THR_POOL;
      hw_q    <= NCNT_W'(MAX_WORKERS);
      rqt_q   <= NCNT_W'(1);
      plen_q  <= '0;
      plan_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCHED_MODE:   sched_q <= cfg_wdata_i[1:0];
        CFG_THREAD_MODE:  thr_q   <= cfg_wdata_i[1:0];
        CFG_HW_THREADS:   hw_q    <= cfg_wdata_i[NCNT_W-1:0];
        CFG_REQ_THREADS:  rqt_q   <= cfg_wdata_i[NCNT_W-1:0];
        CFG_PLAN_LENGTH:  plen_q  <= cfg_wdata_i[NCNT_W-1:0];
        CFG_PLAN_ENTRIES: plan_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp plan length and hardware count
  assign len_eff = (plen_q > NCNT_W'(PLAN_DEPTH)) ? NCNT_W'(PLAN_DEPTH) : plen_q;
  always_comb begin
    priority if (hw_q == '0) begin
      hw_eff = NCNT_W'(1);
    end else if (hw_q > NCNT_W'(MAX_WORKERS)) begin
      hw_eff = NCNT_W'(MAX_WORKERS);
    end else begin
      hw_eff = hw_q;
    end
  end

  // worker count from thread mode
  assign mx_inc = {1'b0, mx_q} + NCNT_W'(1);
  always_comb begin
    unique case (thr_q)
      THR_PLAN: begin
        if (len_eff == '0) begin
          n_d = hw_eff;
        end else begin
          n_d = (mx_inc < hw_eff) ? mx_inc : hw_eff;
        end
      end
      THR_CONST: begin
        if (rqt_q == '0) begin
          n_d = '0;
        end else begin
          n_d = (rqt_q < hw_eff) ? rqt_q : hw_eff;
        end
      end
      default: n_d = hw_eff;
    endcase
  end

  assign pv_scan = plan_value(plan_q, k_q);
  assign pv_rem  = plan_value(plan_q, rem[PLAN_IDX_W-1:0]);

  // remainder operands
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_TID_LEN: begin
        div_dvd = tid_q;
        div_dsr = len_eff;
      end
      DIV_PV_N: begin
        div_dvd = TASK_ID_WIDTH'(pv_rem);
        div_dsr = n_q;
      end
      default: begin
        div_dvd = tid_q;
        div_dsr = n_q;
      end
    endcase
  end

  tds_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  // latch item, scan plan, scan counters, pick worker
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req.req_type;
      tid_q      <= req.task_id;
      dw_q       <= req.done_worker;
      k_q        <= '0;
      mx_q       <= '0;
    end
    if (cmd_i.pscan_step) begin
      k_q <= k_q + PLAN_IDX_W'(1);
      if (pv_scan > mx_q) begin
        mx_q <= pv_scan;
      end
    end
    if (cmd_i.ncalc) begin
      n_q <= n_d;
    end
    if (cmd_i.ascan_clr) begin
      i_q     <= NCNT_W'(1);
      best_q  <= '0;
      bestv_q <= cnt_q[0];
    end
    if (cmd_i.ascan_step) begin
      i_q <= i_q + NCNT_W'(1);
      if (rd_val < bestv_q) begin
        best_q  <= i_q[WORKER_W-1:0];
        bestv_q <= rd_val;
      end
    end
    if (cmd_i.w_load) begin
      w_q <= w_d;
    end
  end

  always_comb begin
    unique case (cmd_i.w_src)
      W_REM:   w_d = rem[WORKER_W-1:0];
      W_MIN:   w_d = best_q;
      default: w_d = dw_q;
    endcase
  end

  // counter read port shared by the counter scan and the update
  assign rd_idx = cmd_i.update ? w_q : i_q[WORKER_W-1:0];
  assign rd_val = cnt_q[rd_idx];

  // result and counter update
  assign dw_out_of_range = ({1'b0, dw_q} >= n_q);
  always_comb begin
    upd_write  = 1'b0;
    upd_val    = rd_val;
    upd_worker = w_q;
    upd_status = ST_OK;
    upd_pend   = '0;
    priority if (n_q == '0) begin
      upd_worker = req_type_q ? dw_q : '0;
      upd_status = ST_COUNT_ERR;
    end else if (req_type_q && dw_out_of_range) begin
      upd_status = ST_IGNORED;
    end else if (req_type_q) begin
      upd_write = 1'b1;
      upd_val   = (rd_val != '0) ? rd_val - COUNT_WIDTH'(1) : rd_val;
      upd_pend  = upd_val;
    end else begin
      upd_write = 1'b1;
      upd_val   = (rd_val != '1) ? rd_val + COUNT_WIDTH'(1) : rd_val;
      upd_pend  = upd_val;
    end
  end

  // pending counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_WORKERS; j++) begin
        cnt_q[j] <= '0;
      end
    end else if (cmd_i.update && upd_write) begin
      cnt_q[w_q] <= upd_val;
    end
  end

  // result register: load on update, drop on transfer
  assign out_free = !out_valid_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_worker_q <= upd_worker;
      out_status_q <= upd_status;
      out_pend_q   <= upd_pend;
    end
  end

  assign req.ready         = cmd_i.in_ready;
  assign rsp.valid         = out_valid_q;
  assign rsp.worker        = out_worker_q;
  assign rsp.status        = out_status_q;
  assign rsp.pending_after = out_pend_q;

  // status to controller
  assign stat_o.in_valid      = req.valid;
  assign stat_o.plan_active   = (thr_q == THR_PLAN) && (len_eff != '0);
  assign stat_o.pscan_last    = ({1'b0, k_q} == len_eff - NCNT_W'(1));
  assign stat_o.n_zero        = (n_q == '0);
  assign stat_o.is_done_req   = req_type_q;
  assign stat_o.sched_planned = (sched_q == SCHED_PLANNED) && (len_eff != '0);
  assign stat_o.sched_rr      = (sched_q == SCHED_PLANNED) || (sched_q == SCHED_RR);
  assign stat_o.div_done      = div_done;
  assign stat_o.ascan_end     = (i_q >= n_q);
  assign stat_o.out_free      = out_free;

endmodule

// File: rtl/task_dispatch_selector_unit.sv
`timescale 1ns / 1ps
// Top level of the task dispatch selector: controller, datapath, checks.
//
//   channel  dir  handshake          payload
//   req      in   valid / ready      req_type, task_id, done_worker
//   rsp      out  valid / ready      worker, status, pending_after
//   cfg      in   cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One item at a time. Completion or count error skip the worker search. Round
// robin and planned picks use the remainder unit (4 bits a cycle over a 32-bit
// id, run once or twice). Least loaded scans the counters, one counter read a
// cycle. Plan-derived thread mode first scans the plan entries one at a time.
// Reset clears the pending counters and resets the settings at once; a stalled
// result waits in the output register while the next item is taken.
module task_dispatch_selector_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tds_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tds_req_if.sink                        req,
  tds_rsp_if.source                      rsp
);
  import tds_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tds_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tds_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req),
    .rsp         (rsp),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

`ifndef SYNTH
  // a result is never written over one still waiting
  a_update_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |-> stat.out_free)
    else $error("result register overwritten");

  // an accepted item closes the input until it is done
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item taken while busy");

  // an ignored completion reports no count
  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && (rsp.status == ST_IGNORED)) |-> (rsp.pending_after == '0))
    else $error("ignored completion with nonzero count");
`endif

endmodule
